// File: rtl/ccs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types, operation codes and sizes for the cooperative context
// selector.
// ----------------------------------------------------------------------------
package ccs_pkg;

   localparam int CTX_ID_W         = 6;
   localparam int MAX_CONTEXTS     = 64;
   localparam int NUM_CONTEXTS_DEF = 64;

   localparam logic [2:0] FUNC_ADD    = 3'd0;
   localparam logic [2:0] FUNC_REMOVE = 3'd1;
   localparam logic [2:0] FUNC_SCHED  = 3'd2;
   localparam logic [2:0] FUNC_YIELD  = 3'd3;
   localparam logic [2:0] FUNC_SELECT = 3'd4;

   typedef struct packed {
      logic [2:0]          func;
      logic [CTX_ID_W-1:0] ctx_id;
      logic                batch_end;
   } req_type;

   typedef struct packed {
      logic [CTX_ID_W-1:0] current_id;
      logic                current_ok;
      logic                reschedule;
      logic                error;
      logic                none_live;
   } rsp_type;

endpackage

// File: rtl/cooperative_context_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cooperative_context_selector
// Keeps a bitmap of live context IDs and one current context; each
// transaction edits or queries them and returns one result.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   busy is held low, so one transaction can be issued in every cycle.
//   req_data carries func, ctx_id and batch_end.
//   The result appears on rsp_data for exactly one cycle with rsp_strobe
//   high, once the transaction has passed the request register and then
//   the priority encoders into the result register. Results come back in
//   issue order, one per transaction, and a transaction sees the state
//   left by every earlier one.
//   Throughput is one transaction per cycle, set by the single pass of
//   lowest, highest and next-lower live ID encoders over the bitmap.
//   The receiver cannot stall; rsp_data must be captured on the strobe.
//   Synchronous reset empties the bitmap, drops the current context and
//   discards any transaction in flight.
// ----------------------------------------------------------------------------
module cooperative_context_selector #(
   parameter int NUM_CONTEXTS = ccs_pkg::NUM_CONTEXTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ccs_pkg::req_type req_data,
   output logic             rsp_strobe,
   output ccs_pkg::rsp_type rsp_data
);

   localparam int MAP_W = (NUM_CONTEXTS < ccs_pkg::MAX_CONTEXTS) ?
                          NUM_CONTEXTS : ccs_pkg::MAX_CONTEXTS;
   localparam int ID_W  = $clog2(MAP_W);

   function automatic logic [MAP_W-1:0] bit_rev(input logic [MAP_W-1:0] x);
      logic [MAP_W-1:0] r;
      r = '0;
      for (int i = 0; i < MAP_W; i++) begin
         r[i] = x[MAP_W-1-i];
      end
      return r;
   endfunction

   function automatic logic [ID_W-1:0] oh_encode(input logic [MAP_W-1:0] oh);
      logic [ID_W-1:0] id;
      id = '0;
      for (int b = 0; b < ID_W; b++) begin
         for (int i = 0; i < MAP_W; i++) begin
            if (((i >> b) & 1) == 1) begin
               id[b] = id[b] | oh[i];
            end
         end
      end
      return id;
   endfunction

   function automatic logic [ID_W-1:0] lowest_id(input logic [MAP_W-1:0] x);
      return oh_encode(x & (~x + MAP_W'(1)));
   endfunction

   function automatic logic [ID_W-1:0] highest_id(input logic [MAP_W-1:0] x);
      logic [MAP_W-1:0] r;
      r = bit_rev(x);
      return oh_encode(bit_rev(r & (~r + MAP_W'(1))));
   endfunction

   logic                 req_valid_ff;
   ccs_pkg::req_type     req_ff;
   logic [MAP_W-1:0]     live_ff, live_in;
   logic [ID_W-1:0]      cur_ff, cur_in;
   logic                 cur_valid_ff, cur_valid_in;
   logic                 rsp_strobe_ff;
   ccs_pkg::rsp_type     rsp_ff, rsp_in;

   logic                 usable;
   logic [ID_W-1:0]      id_s;
   logic [MAP_W-1:0]     id_oh;
   logic [MAP_W-1:0]     below;
   logic                 single_live;
   logic                 resched;
   logic                 err;
   logic [ID_W-1:0]      rep_id;
   logic                 rep_ok;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         live_ff       <= '0;
         cur_ff        <= '0;
         cur_valid_ff  <= 1'b0;
      end else begin
         req_valid_ff  <= start && !busy;
         rsp_strobe_ff <= req_valid_ff;
         if (req_valid_ff) begin
            live_ff      <= live_in;
            cur_ff       <= cur_in;
            cur_valid_ff <= cur_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   always_comb begin
      usable      = {1'b0, req_ff.ctx_id} < (ccs_pkg::CTX_ID_W + 1)'(MAP_W);
      id_s        = req_ff.ctx_id[ID_W-1:0];
      id_oh       = MAP_W'(1) << id_s;
      below       = live_ff & ((MAP_W'(1) << cur_ff) - MAP_W'(1));
      single_live = (live_ff != '0) && ((live_ff & (live_ff - MAP_W'(1))) == '0);
      live_in      = live_ff;
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      resched      = 1'b0;
      err          = 1'b0;
      case (req_ff.func)
         ccs_pkg::FUNC_ADD, ccs_pkg::FUNC_REMOVE: begin
            if (!usable) begin
               err = 1'b1;
            end else begin
               if (req_ff.func == ccs_pkg::FUNC_ADD) begin
                  live_in = live_ff | id_oh;
               end else begin
                  live_in = live_ff & ~id_oh;
                  if (cur_valid_ff && (cur_ff == id_s)) begin
                     cur_valid_in = 1'b0;
                  end
               end
               if (req_ff.batch_end && !cur_valid_in && (live_in != '0)) begin
                  cur_in       = lowest_id(live_in);
                  cur_valid_in = 1'b1;
               end
            end
         end
         ccs_pkg::FUNC_SCHED: begin
            if (!usable || !live_ff[id_s]) begin
               err = 1'b1;
            end else begin
               cur_in       = id_s;
               cur_valid_in = 1'b1;
               resched      = 1'b1;
            end
         end
         ccs_pkg::FUNC_YIELD: begin
            if (!single_live) begin
               if (!cur_valid_ff) begin
                  err = 1'b1;
               end else begin
                  cur_in  = (below != '0) ? highest_id(below) : highest_id(live_ff);
                  resched = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      rep_id = cur_valid_in ? cur_in : '0;
      rep_ok = cur_valid_in;
      if ((req_ff.func == ccs_pkg::FUNC_SELECT) && !cur_valid_in) begin
         if (live_in != '0) begin
            rep_id = lowest_id(live_in);
            rep_ok = 1'b1;
         end else begin
            err = 1'b1;
         end
      end
      rsp_in.current_id = ccs_pkg::CTX_ID_W'(rep_id);
      rsp_in.current_ok = rep_ok;
      rsp_in.reschedule = resched;
      rsp_in.error      = err;
      rsp_in.none_live  = (live_in == '0);
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // current context always names a live ID
   assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> live_ff[cur_ff])
      else $error("current context not live");

   // every transaction returns one result
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("missing result strobe");

   // a rejected transaction never reschedules
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_data.error && rsp_data.reschedule))
      else $error("error with reschedule");

   // an empty set names no context
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.none_live) |-> !rsp_data.current_ok)
      else $error("context reported on empty set");

endmodule

// File: tb/tb_cooperative_context_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cooperative_context_selector
// Self-checking bench for the context selector. A short directed sequence
// walks the empty set, single-context yields, wrap-around, dropped and
// reselected contexts and the unknown operation codes. Three random phases
// follow with different sender idle rates. Every transaction is run through
// a cycle-free model of the live bitmap and current context. Each strobed
// result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_cooperative_context_selector;

   localparam int CTX_ID_W     = ccs_pkg::CTX_ID_W;
   localparam int MAX_CONTEXTS = ccs_pkg::MAX_CONTEXTS;
   localparam int NUM_CTX      = ccs_pkg::NUM_CONTEXTS_DEF;
   localparam int ID_LIMIT     = (NUM_CTX < MAX_CONTEXTS) ? NUM_CTX : MAX_CONTEXTS;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS  = 300;

   class ctx_scoreboard;
      logic [MAX_CONTEXTS-1:0] live_map;
      logic [CTX_ID_W-1:0]     cur_ctx;
      logic                    cur_valid;
      ccs_pkg::rsp_type        want_q[$];
      int                      n_req;
      int                      n_rsp;
      int                      n_rejected;
      int                      n_resched;
      int                      n_empty;
      int                      n_mismatch;

      function new();
         live_map   = '0;
         cur_ctx    = '0;
         cur_valid  = 1'b0;
         n_req      = 0;
         n_rsp      = 0;
         n_rejected = 0;
         n_resched  = 0;
         n_empty    = 0;
         n_mismatch = 0;
      endfunction

      function int pending();
         return want_q.size();
      endfunction

      function logic [CTX_ID_W-1:0] lowest_live();
         for (int k = MAX_CONTEXTS - 1; k >= 0; k--)
            if (live_map[k]) lowest_live = CTX_ID_W'(k);
         if (live_map == '0) lowest_live = '0;
      endfunction

      function logic [CTX_ID_W-1:0] highest_live();
         for (int k = 0; k < MAX_CONTEXTS; k++)
            if (live_map[k]) highest_live = CTX_ID_W'(k);
         if (live_map == '0) highest_live = '0;
      endfunction

      function logic [CTX_ID_W-1:0] pick_live();
         int ids[$];
         for (int k = 0; k < MAX_CONTEXTS; k++)
            if (live_map[k]) ids.push_back(k);
         if (ids.size() == 0) return CTX_ID_W'($urandom_range(0, MAX_CONTEXTS - 1));
         return CTX_ID_W'(ids[$urandom_range(0, ids.size() - 1)]);
      endfunction

      function void note_request(ccs_pkg::req_type t);
         ccs_pkg::rsp_type    want;
         logic                usable;
         logic                resched;
         logic                err;
         logic                found;
         logic [CTX_ID_W-1:0] nxt;
         usable  = int'(t.ctx_id) < ID_LIMIT;
         resched = 1'b0;
         err     = 1'b0;
         n_req++;
         case (t.func)
            ccs_pkg::FUNC_ADD, ccs_pkg::FUNC_REMOVE: begin
               if (!usable) begin
                  err = 1'b1;
               end else begin
                  if (t.func == ccs_pkg::FUNC_ADD) begin
                     live_map[t.ctx_id] = 1'b1;
                  end else begin
                     live_map[t.ctx_id] = 1'b0;
                     if (cur_valid && cur_ctx == t.ctx_id) cur_valid = 1'b0;
                  end
                  if (t.batch_end && !cur_valid && live_map != '0) begin
                     cur_ctx   = lowest_live();
                     cur_valid = 1'b1;
                  end
               end
            end
            ccs_pkg::FUNC_SCHED: begin
               if (!usable || !live_map[t.ctx_id]) begin
                  err = 1'b1;
               end else begin
                  cur_ctx   = t.ctx_id;
                  cur_valid = 1'b1;
                  resched   = 1'b1;
               end
            end
            ccs_pkg::FUNC_YIELD: begin
               if ($countones(live_map) != 1) begin
                  if (!cur_valid) begin
                     err = 1'b1;
                  end else begin
                     nxt   = highest_live();
                     found = 1'b0;
                     for (int k = int'(cur_ctx) - 1; k >= 0; k--)
                        if (!found && live_map[k]) begin
                           nxt   = CTX_ID_W'(k);
                           found = 1'b1;
                        end
                     cur_ctx = nxt;
                     resched = 1'b1;
                  end
               end
            end
            default: ;
         endcase
         want.current_id = cur_valid ? cur_ctx : '0;
         want.current_ok = cur_valid;
         if (t.func == ccs_pkg::FUNC_SELECT && !cur_valid) begin
            if (live_map != '0) begin
               want.current_id = lowest_live();
               want.current_ok = 1'b1;
            end else begin
               err = 1'b1;
            end
         end
         want.reschedule = resched;
         want.error      = err;
         want.none_live  = (live_map == '0);
         if (err) n_rejected++;
         if (resched) n_resched++;
         if (live_map == '0) n_empty++;
         want_q.push_back(want);
      endfunction

      task report_mismatch(string msg);
         n_mismatch++;
         if (n_mismatch <= 20) $display("MISMATCH at result %0d: %s", n_rsp, msg);
      endtask

      task check_result(ccs_pkg::rsp_type got);
         ccs_pkg::rsp_type want;
         n_rsp++;
         if (want_q.size() == 0) begin
            report_mismatch("result with no transaction outstanding");
         end else begin
            want = want_q.pop_front();
            if (got.current_id !== want.current_id)
               report_mismatch($sformatf("current_id %0d, want %0d",
                  got.current_id, want.current_id));
            if (got.current_ok !== want.current_ok)
               report_mismatch($sformatf("current_ok %b, want %b",
                  got.current_ok, want.current_ok));
            if (got.reschedule !== want.reschedule)
               report_mismatch($sformatf("reschedule %b, want %b",
                  got.reschedule, want.reschedule));
            if (got.error !== want.error)
               report_mismatch($sformatf("error %b, want %b", got.error, want.error));
            if (got.none_live !== want.none_live)
               report_mismatch($sformatf("none_live %b, want %b",
                  got.none_live, want.none_live));
         end
      endtask

      task check_drained();
         if (want_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", want_q.size()));
      endtask
   endclass

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   ccs_pkg::req_type req_data = '0;
   logic             busy;
   logic             rsp_strobe;
   ccs_pkg::rsp_type rsp_data;

   ctx_scoreboard sb;
   int            stall_count = 0;
   int            id_base     = 0;

   cooperative_context_selector #(
      .NUM_CONTEXTS(NUM_CTX)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   always begin
      #2;
      clock = 1'b1;
      #2;
      clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_count <= 0;
      end else begin
         if (start && !busy) sb.note_request(req_data);
         if (rsp_strobe) sb.check_result(rsp_data);
         if ((start && !busy) || rsp_strobe) begin
            stall_count <= 0;
         end else if (stall_count >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end else begin
            stall_count <= stall_count + 1;
         end
      end
   end

   function ccs_pkg::req_type mk(logic [2:0] func, int id, bit batch);
      ccs_pkg::req_type t;
      t.func      = func;
      t.ctx_id    = CTX_ID_W'(id);
      t.batch_end = batch;
      return t;
   endfunction

   task send_item(ccs_pkg::req_type t, int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (busy);
   endtask

   task drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function ccs_pkg::req_type random_item(int add_w);
      ccs_pkg::req_type t;
      int               r;
      if ($urandom_range(0, 39) == 0) id_base = $urandom_range(0, MAX_CONTEXTS - 8);
      r = $urandom_range(0, add_w + 69);
      if (r < add_w) t.func = ccs_pkg::FUNC_ADD;
      else if (r < add_w + 25) t.func = ccs_pkg::FUNC_REMOVE;
      else if (r < add_w + 38) t.func = ccs_pkg::FUNC_SCHED;
      else if (r < add_w + 52) t.func = ccs_pkg::FUNC_YIELD;
      else if (r < add_w + 64) t.func = ccs_pkg::FUNC_SELECT;
      else t.func = 3'($urandom_range(5, 7));
      if (t.func == ccs_pkg::FUNC_SCHED && $urandom_range(0, 3) != 0)
         t.ctx_id = sb.pick_live();
      else if ($urandom_range(0, 4) == 0)
         t.ctx_id = CTX_ID_W'($urandom_range(0, MAX_CONTEXTS - 1));
      else
         t.ctx_id = CTX_ID_W'(id_base + $urandom_range(0, 7));
      t.batch_end = ($urandom_range(0, 2) == 0);
      return t;
   endfunction

   task run_random(int count, int idle_pct, int add_w);
      for (int n = 0; n < count; n++) send_item(random_item(add_w), idle_pct);
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(mk(ccs_pkg::FUNC_SELECT, 0, 0), 0);
      send_item(mk(ccs_pkg::FUNC_YIELD, 0, 0), 0);
      send_item(mk(ccs_pkg::FUNC_SCHED, 5, 0), 0);
      send_item(mk(ccs_pkg::FUNC_REMOVE, 7, 1), 0);
      send_item(mk(ccs_pkg::FUNC_ADD, 0, 0), 0);
      send_item(mk(ccs_pkg::FUNC_YIELD, 0, 0), 0);
      send_item(mk(ccs_pkg::FUNC_ADD, 63, 1), 0);
      send_item(mk(ccs_pkg::FUNC_SELECT, 0, 1), 0);
      send_item(mk(ccs_pkg::FUNC_YIELD, 0, 0), 0);
      send_item(mk(ccs_pkg::FUNC_YIELD, 63, 1), 0);
      send_item(mk(ccs_pkg::FUNC_SCHED, 63, 0), 0);
      send_item(mk(ccs_pkg::FUNC_REMOVE, 63, 0), 0);
      send_item(mk(ccs_pkg::FUNC_SELECT, 0, 0), 0);
      send_item(mk(ccs_pkg::FUNC_ADD, 31, 0), 0);
      send_item(mk(ccs_pkg::FUNC_YIELD, 0, 0), 0);
      send_item(mk(3'd5, 63, 1), 0);
      send_item(mk(3'd6, 63, 1), 0);
      send_item(mk(3'd7, 63, 1), 0);
      send_item(mk(ccs_pkg::FUNC_ADD, 42, 1), 0);
      send_item(mk(ccs_pkg::FUNC_REMOVE, 0, 1), 0);
      send_item(mk(ccs_pkg::FUNC_SCHED, 42, 0), 0);
      send_item(mk(ccs_pkg::FUNC_YIELD, 0, 0), 0);
      send_item(mk(ccs_pkg::FUNC_REMOVE, 31, 0), 0);
      send_item(mk(ccs_pkg::FUNC_REMOVE, 42, 1), 0);
      send_item(mk(ccs_pkg::FUNC_SELECT, 0, 0), 0);
      drain();

      run_random(PHASE_ITEMS, 26, 30);
      drain();
      run_random(PHASE_ITEMS, 61, 20);
      drain();
      run_random(PHASE_ITEMS, 0, 35);
      start <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.check_drained();

      $display("covered %0d transactions and %0d results over three idle mixes",
         sb.n_req, sb.n_rsp);
      $display("%0d rejected, %0d reschedules, %0d results with an empty set",
         sb.n_rejected, sb.n_resched, sb.n_empty);
      if (sb.n_mismatch == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
